/* sv/pclfu_pkg.sv */
// shared types and constants for the lfu page cache with count decay
// no dependencies
`default_nettype none

package pclfu_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;
  localparam int LPP_W      = 5;
  localparam int PERIOD_W   = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_LPP_LOG2     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 1'd1;

  localparam logic [LPP_W-1:0]    LPP_RESET    = 5'd6;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd4096;

  // fixed widths of result fields
  localparam int FRAME_OUT_W = 6;
  localparam int PAGE_OUT_W  = 48;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_LOOK,
    OP_ALLOC,
    OP_MIN,
    OP_HIT_RD,
    OP_HIT_WR,
    OP_INSTALL,
    OP_TICK,
    OP_DECAY,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC,
    S_MIN,
    S_HIT_RD,
    S_HIT_WR,
    S_INSTALL,
    S_TICK,
    S_DECAY,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic match;
    logic look_end;
    logic full;
    logic scan_end;
    logic decay_due;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/pclfu_dp.sv */
// datapath: tag and count memories, scan pointer, victim tracking, output register
// depends on pclfu_pkg
`default_nettype none

module pclfu_dp import pclfu_pkg::*; #(
  parameter int NUM_PAGES   = 64,
  parameter int COUNT_WIDTH = 32,
  parameter int ADDR_WIDTH  = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_op_t                 op,
  output dp_stat_t                    stat,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [ADDR_WIDTH-1:0]  in_line_addr,
  input  wire logic                   in_is_write,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_hit,
  output logic [FRAME_OUT_W-1:0]      out_frame,
  output logic                        out_evict_valid,
  output logic                        out_evict_dirty,
  output logic [PAGE_OUT_W-1:0]       out_evicted_page,
  output logic                        out_decayed
);

  localparam int IW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int EW = ADDR_WIDTH + 1;
  localparam logic [CW-1:0]          N_C     = CW'(NUM_PAGES);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // memories: entry is {dirty, tag}
  logic [EW-1:0]          tag_mem [NUM_PAGES];
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_PAGES];
  logic [EW-1:0]          tag_q_r;
  logic [COUNT_WIDTH-1:0] cnt_q_r;

  logic [LPP_W-1:0]       lpp_r;
  logic [PERIOD_W-1:0]    period_r;
  logic [PERIOD_W-1:0]    acc_r;
  logic [CW-1:0]          fill_r;
  logic [CW-1:0]          idx_r;
  logic                   pv_r;
  logic [CW-1:0]          pidx_r;
  logic [ADDR_WIDTH-1:0]  page_r;
  logic                   wr_r;
  logic [IW-1:0]          fr_r;
  logic                   hit_r;
  logic                   ev_valid_r;
  logic                   ev_dirty_r;
  logic [ADDR_WIDTH-1:0]  ev_tag_r;
  logic [COUNT_WIDTH-1:0] best_r;
  logic                   decayed_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic                   out_evict_valid_r;
  logic                   out_evict_dirty_r;
  logic [PAGE_OUT_W-1:0]  out_evicted_page_r;
  logic                   out_decayed_r;

  logic                   tag_hit;
  logic                   idx_lt_fill;
  logic                   idx_lt_n;
  logic                   issue;
  logic                   tag_re;
  logic                   cnt_re;
  logic [IW-1:0]          cnt_ra;
  logic                   tag_we;
  logic [EW-1:0]          tag_wd;
  logic                   cnt_we;
  logic [IW-1:0]          cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic [PERIOD_W-1:0]    acc_inc;
  logic                   decay_due;
  logic                   out_free;
  logic [ADDR_WIDTH-1:0]  page_in;
  logic                   min_take;

  assign page_in     = in_line_addr >> lpp_r;
  assign tag_hit     = pv_r && (tag_q_r[ADDR_WIDTH-1:0] == page_r);
  assign idx_lt_fill = idx_r < fill_r;
  assign idx_lt_n    = idx_r < N_C;
  assign acc_inc     = acc_r + 1'b1;
  assign decay_due   = acc_inc >= period_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign min_take    = pv_r && ((pidx_r == '0) || (cnt_q_r < best_r));

  always_comb begin
    issue  = 1'b0;
    tag_we = 1'b0;
    tag_wd = {1'b1, page_r};
    cnt_we = 1'b0;
    cnt_wa = fr_r;
    cnt_wd = CNT_ONE;
    unique case (op)
      OP_LOOK: begin
        issue = idx_lt_fill && !tag_hit;
      end
      OP_MIN: begin
        issue = idx_lt_n;
      end
      OP_HIT_WR: begin
        tag_we = wr_r;
        cnt_we = 1'b1;
        cnt_wd = (cnt_q_r == CNT_MAX) ? cnt_q_r : cnt_q_r + 1'b1;
      end
      OP_INSTALL: begin
        tag_we = 1'b1;
        tag_wd = {wr_r, page_r};
        cnt_we = 1'b1;
      end
      OP_DECAY: begin
        issue  = idx_lt_n;
        cnt_we = pv_r;
        cnt_wa = pidx_r[IW-1:0];
        cnt_wd = cnt_q_r >> 1;
      end
      default: begin
      end
    endcase
    tag_re = issue;
    cnt_re = issue || (op == OP_HIT_RD);
    cnt_ra = (op == OP_HIT_RD) ? fr_r : idx_r[IW-1:0];
  end

  always_comb begin
    stat.match     = tag_hit;
    stat.look_end  = !idx_lt_fill && !pv_r;
    stat.full      = fill_r == N_C;
    stat.scan_end  = !idx_lt_n && !pv_r;
    stat.decay_due = decay_due;
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[fr_r] <= tag_wd;
    end
    if (tag_re) begin
      tag_q_r <= tag_mem[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_q_r <= cnt_mem[cnt_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpp_r       <= LPP_RESET;
      period_r    <= PERIOD_RESET;
      acc_r       <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LPP_LOG2:     lpp_r    <= cfg_wdata[LPP_W-1:0];
          CFG_DECAY_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        endcase
      end
      pv_r <= issue;
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end else if (op == OP_START || op == OP_ALLOC || op == OP_TICK) begin
        idx_r <= '0;
      end
      if (op == OP_ALLOC && !stat.full) begin
        fill_r <= fill_r + 1'b1;
      end
      if (op == OP_TICK) begin
        acc_r <= decay_due ? '0 : acc_inc;
      end
      if (op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and result fields
  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    unique case (op)
      OP_START: begin
        page_r     <= page_in;
        wr_r       <= in_is_write;
        hit_r      <= 1'b0;
        ev_valid_r <= 1'b0;
        ev_dirty_r <= 1'b0;
        ev_tag_r   <= '0;
        decayed_r  <= 1'b0;
      end
      OP_LOOK: begin
        if (tag_hit) begin
          hit_r <= 1'b1;
          fr_r  <= pidx_r[IW-1:0];
        end
      end
      OP_ALLOC: begin
        if (!stat.full) begin
          fr_r <= fill_r[IW-1:0];
        end
      end
      OP_MIN: begin
        // strict less-than keeps the lowest index on ties
        if (min_take) begin
          best_r     <= cnt_q_r;
          fr_r       <= pidx_r[IW-1:0];
          ev_valid_r <= 1'b1;
          ev_dirty_r <= tag_q_r[ADDR_WIDTH];
          ev_tag_r   <= tag_q_r[ADDR_WIDTH-1:0];
        end
      end
      OP_TICK: begin
        decayed_r <= decay_due;
      end
      OP_OUT: begin
        out_hit_r          <= hit_r;
        out_frame_r        <= FRAME_OUT_W'(fr_r);
        out_evict_valid_r  <= ev_valid_r;
        out_evict_dirty_r  <= ev_dirty_r;
        out_evicted_page_r <= PAGE_OUT_W'(ev_tag_r);
        out_decayed_r      <= decayed_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame        = out_frame_r;
  assign out_evict_valid  = out_evict_valid_r;
  assign out_evict_dirty  = out_evict_dirty_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_decayed      = out_decayed_r;

endmodule

`default_nettype wire

/* sv/pclfu_ctrl.sv */
// controller: sequences lookup, allocation, victim scan, count update and decay sweep
// depends on pclfu_pkg
`default_nettype none

module pclfu_ctrl import pclfu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_op_t        op
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op        = OP_START;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        op = OP_LOOK;
        if (stat.match) begin
          state_nxt = S_HIT_RD;
        end else if (stat.look_end) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        op        = OP_ALLOC;
        state_nxt = stat.full ? S_MIN : S_INSTALL;
      end
      S_MIN: begin
        op = OP_MIN;
        if (stat.scan_end) begin
          state_nxt = S_INSTALL;
        end
      end
      S_HIT_RD: begin
        op        = OP_HIT_RD;
        state_nxt = S_HIT_WR;
      end
      S_HIT_WR: begin
        op        = OP_HIT_WR;
        state_nxt = S_TICK;
      end
      S_INSTALL: begin
        op        = OP_INSTALL;
        state_nxt = S_TICK;
      end
      S_TICK: begin
        op        = OP_TICK;
        state_nxt = stat.decay_due ? S_DECAY : S_DONE;
      end
      S_DECAY: begin
        op = OP_DECAY;
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/page_cache_lfu_with_decay.sv */
// top level of the lfu page cache with periodic count halving
// depends on pclfu_pkg, pclfu_ctrl, pclfu_dp
`default_nettype none

// Fully associative cache of NUM_PAGES page frames with least-frequently-used
// replacement. One request at a time: a lookup walks the tag memory one frame
// a cycle, stopping on a hit and covering only the frames in use; a miss
// with all frames in use walks the count memory for the victim; every
// decay_period requests a sweep halves all counts. The walks go frame by
// frame, set by the one read port of the tag and count memories.
// Frames fill in index order and stay valid, so no clearing pass follows
// reset. The next request is taken while a result waits in the output
// register.
module page_cache_lfu_with_decay import pclfu_pkg::*; #(
  parameter int NUM_PAGES   = 64,
  parameter int COUNT_WIDTH = 32,
  parameter int ADDR_WIDTH  = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ADDR_WIDTH-1:0] in_line_addr,
  input  wire logic                  in_is_write,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic [FRAME_OUT_W-1:0]     out_frame,
  output logic                       out_evict_valid,
  output logic                       out_evict_dirty,
  output logic [PAGE_OUT_W-1:0]      out_evicted_page,
  output logic                       out_decayed
);

  dp_op_t   op;
  dp_stat_t stat;

  pclfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  pclfu_dp #(
    .NUM_PAGES   (NUM_PAGES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_line_addr     (in_line_addr),
    .in_is_write      (in_is_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_frame        (out_frame),
    .out_evict_valid  (out_evict_valid),
    .out_evict_dirty  (out_evict_dirty),
    .out_evicted_page (out_evicted_page),
    .out_decayed      (out_decayed)
  );

endmodule

`default_nettype wire

/* tb/page_cache_lfu_with_decay_tb.sv */
// self-checking testbench for the lfu page cache with periodic count halving
// drives directed and random requests, checks every result against a local cache model or a directed expected value
// depends on pclfu_pkg and page_cache_lfu_with_decay
`default_nettype none

module page_cache_lfu_with_decay_tb;
  import pclfu_pkg::*;

  localparam int NUM_FRAMES = 64;
  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 32;
  localparam int MAX_GAP    = 17;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 3 * NUM_FRAMES + 40;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   evict_valid;
    logic                   evict_dirty;
    logic [PAGE_OUT_W-1:0]  evicted_page;
    logic                   decayed;
  } page_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0]     addr;
    logic                  wr;
    bit                    typed;
    page_result_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LPP_LOG2;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     in_line_addr = '0;
  logic                  in_is_write = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [FRAME_OUT_W-1:0] out_frame;
  logic                  out_evict_valid;
  logic                  out_evict_dirty;
  logic [PAGE_OUT_W-1:0] out_evicted_page;
  logic                  out_decayed;

  page_cache_lfu_with_decay #(
    .NUM_PAGES(NUM_FRAMES),
    .COUNT_WIDTH(CNT_W),
    .ADDR_WIDTH(ADDR_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_line_addr(in_line_addr),
    .in_is_write(in_is_write),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_frame(out_frame),
    .out_evict_valid(out_evict_valid),
    .out_evict_dirty(out_evict_dirty),
    .out_evicted_page(out_evicted_page),
    .out_decayed(out_decayed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cache model state
  logic [ADDR_W-1:0]   tag_mem [NUM_FRAMES];
  bit                  frame_live [NUM_FRAMES];
  bit                  frame_dirt [NUM_FRAMES];
  logic [CNT_W-1:0]    use_cnt [NUM_FRAMES];
  logic [PERIOD_W-1:0] access_cnt;
  logic [LPP_W-1:0]    page_shift;
  logic [PERIOD_W-1:0] halving_period;

  page_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int n_errors  = 0;
  int n_results = 0;
  bit tx_burst  = 1'b0;
  bit rx_burst  = 1'b0;

  function automatic page_result_t cache_access(logic [ADDR_W-1:0] addr, logic wr);
    logic [ADDR_W-1:0] page;
    page_result_t r;
    int i;
    int fr;
    bit found;
    page  = addr >> page_shift;
    r     = '0;
    found = 1'b0;
    fr    = 0;
    for (i = 0; i < NUM_FRAMES; i++) begin
      if (!found && frame_live[i] && tag_mem[i] == page) begin
        found = 1'b1;
        fr    = i;
      end
    end
    r.hit = found;
    if (found) begin
      if (use_cnt[fr] != '1) use_cnt[fr] = use_cnt[fr] + 1'b1;
      if (wr) frame_dirt[fr] = 1'b1;
    end else begin
      // victim: lowest free frame, else lowest count with ties to lowest index
      for (i = NUM_FRAMES - 1; i >= 0; i--) begin
        if (!frame_live[i]) begin
          found = 1'b1;
          fr    = i;
        end
      end
      if (!found) begin
        fr = 0;
        for (i = 1; i < NUM_FRAMES; i++) begin
          if (use_cnt[i] < use_cnt[fr]) fr = i;
        end
        r.evict_valid  = 1'b1;
        r.evict_dirty  = frame_dirt[fr];
        r.evicted_page = tag_mem[fr];
      end
      frame_live[fr] = 1'b1;
      frame_dirt[fr] = wr;
      tag_mem[fr]    = page;
      use_cnt[fr]    = 1;
    end
    r.frame    = fr[FRAME_OUT_W-1:0];
    access_cnt = access_cnt + 1'b1;
    if (access_cnt >= halving_period) begin
      for (i = 0; i < NUM_FRAMES; i++) use_cnt[i] = use_cnt[i] >> 1;
      access_cnt = '0;
      r.decayed  = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want, n_results);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LPP_LOG2) page_shift = data[LPP_W-1:0];
    else halving_period = data[PERIOD_W-1:0];
  endtask

  // sender stops and waits until every pending result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_access(logic [ADDR_W-1:0] addr, logic wr, bit typed, page_result_t want);
    int gap;
    page_result_t pred;
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_line_addr <= addr;
    in_is_write  <= wr;
    do @(posedge clk); while (in_stall);
    pred = cache_access(addr, wr);
    pending_results = {pending_results, (typed ? want : pred)};
  endtask

  task automatic add_access(logic [ADDR_W-1:0] addr, logic wr, bit typed, page_result_t want);
    stim_row_t row;
    row        = '{default: '0};
    row.addr   = addr;
    row.wr     = wr;
    row.typed  = typed;
    row.want   = want;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    directed_rows = {directed_rows, row};
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    page_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 64'd1, 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", 64'(out_hit), 64'(e.hit));
        if (out_frame !== e.frame) report_mismatch("frame", 64'(out_frame), 64'(e.frame));
        if (out_evict_valid !== e.evict_valid)
          report_mismatch("evict_valid", 64'(out_evict_valid), 64'(e.evict_valid));
        if (out_evict_dirty !== e.evict_dirty)
          report_mismatch("evict_dirty", 64'(out_evict_dirty), 64'(e.evict_dirty));
        if (out_evicted_page !== e.evicted_page)
          report_mismatch("evicted_page", 64'(out_evicted_page), 64'(e.evicted_page));
        if (out_decayed !== e.decayed)
          report_mismatch("decayed", 64'(out_decayed), 64'(e.decayed));
      end
      n_results++;
    end
  end

  // receiver: random stall after each result, with stretches of none
  int rx_seen = 0;
  int rx_gap  = 0;
  always @(negedge clk) begin
    if (n_results != rx_seen) begin
      rx_seen = n_results;
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap = rx_gap - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no request or result moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    int k;
    int r;
    int pool;
    int n_items;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] page;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] lmask;
    logic [ADDR_W-1:0] pmask;
    logic [LPP_W-1:0] lpp;
    logic [PERIOD_W-1:0] period;
    stim_row_t row;

    for (i = 0; i < NUM_FRAMES; i++) begin
      tag_mem[i]    = '0;
      frame_live[i] = 1'b0;
      frame_dirt[i] = 1'b0;
      use_cnt[i]    = '0;
    end
    access_cnt     = '0;
    page_shift     = LPP_RESET;
    halving_period = PERIOD_RESET;

    // directed part, reset settings first
    add_access(48'h0, 1'b0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 48'd0, 1'b0});
    add_access(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b0, 6'd1, 1'b0, 1'b0, 48'd0, 1'b0});
    add_access(48'h3F, 1'b0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 48'd0, 1'b0});
    add_access(48'hFFFF_FFFF_FFC0, 1'b1, 1'b1, '{1'b1, 6'd1, 1'b0, 1'b0, 48'd0, 1'b0});
    // shift of zero with junk in the upper data bits, old tags still resident
    add_cfg(CFG_LPP_LOG2, 25'h1FF_FFE0);
    add_access(48'h0, 1'b1, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 48'd0, 1'b0});
    add_access(48'h1, 1'b0, 1'b1, '{1'b0, 6'd2, 1'b0, 1'b0, 48'd0, 1'b0});
    // shift beyond the nominal range
    add_cfg(CFG_LPP_LOG2, 25'd31);
    add_access(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, '{1'b0, 6'd3, 1'b0, 1'b0, 48'd0, 1'b0});
    add_access(48'h7FFF_FFFF, 1'b1, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 48'd0, 1'b0});
    add_cfg(CFG_LPP_LOG2, 25'd17);
    add_access(48'h8000_0000_0000, 1'b1, 1'b0, '0);
    add_access(48'h2_0000, 1'b0, 1'b0, '0);
    // zero period halves after every request
    add_cfg(CFG_DECAY_PERIOD, 25'd0);
    add_access(48'h1_FFFF, 1'b0, 1'b0, '0);
    add_access(48'h4_0000, 1'b1, 1'b0, '0);
    add_cfg(CFG_DECAY_PERIOD, 25'h1FF_FFFF);
    add_access(48'h0, 1'b0, 1'b0, '0);
    add_access(48'h8000_0000_0000, 1'b0, 1'b0, '0);
    add_access(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, '0);
    add_access(48'h4_0001, 1'b0, 1'b0, '0);
    // period dropped below the running counter
    add_cfg(CFG_DECAY_PERIOD, 25'd2);
    add_access(48'h0, 1'b0, 1'b0, '0);
    add_access(48'h6_0000, 1'b1, 1'b0, '0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_access(row.addr, row.wr, row.typed, row.want);
      end
    end

    // random phases; frames stay resident across shift changes
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin lpp = 5'd6;  period = PERIOD_RESET; end
        1: begin lpp = 5'd0;  period = 25'd1; end
        2: begin lpp = 5'd12; period = 25'd7; end
        3: begin lpp = 5'd31; period = 25'd0; end
        4: begin lpp = 5'd16; period = 25'h1FF_FFFF; end
        default: begin
          lpp    = LPP_W'($urandom_range(0, 31));
          period = PERIOD_W'($urandom_range(1, 40));
        end
      endcase
      wait_idle();
      write_reg(CFG_LPP_LOG2, CFG_DATA_W'(($urandom & 25'h1FF_FFE0) | lpp));
      write_reg(CFG_DECAY_PERIOD, period);
      base    = ADDR_W'({$urandom, $urandom});
      pool    = $urandom_range(40, 110);
      n_items = 105 + $urandom_range(0, 10);
      lmask   = (48'd1 << lpp) - 1'b1;
      pmask   = 48'hFFFF_FFFF_FFFF >> lpp;
      for (k = 0; k < n_items; k++) begin
        if (phase == 5 && k == n_items / 2) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          addr = ADDR_W'({$urandom, $urandom});
        end else begin
          // hot pages build up counts, the wider pool forces evictions
          page = base + ADDR_W'(r < 55 ? $urandom_range(0, 11) : $urandom_range(0, pool - 1));
          addr = ((page & pmask) << lpp) | (ADDR_W'({$urandom, $urandom}) & lmask);
        end
        send_access(addr, $urandom_range(0, 2) == 0, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/pclfu_pkg.sv
sv/pclfu_dp.sv
sv/pclfu_ctrl.sv
sv/page_cache_lfu_with_decay.sv
tb/page_cache_lfu_with_decay_tb.sv
